/* rtl/core/vtpg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vtpg_pkg
// Shared types and constants of the video test pattern generator.
// ----------------------------------------------------------------------------
package vtpg_pkg;

  localparam int MAX_SIDE_DEF = 4096;
  // Quotient bits of the pipelined dividers; every numerator fits 20 bits.
  localparam int DIV_NW = 20;

  localparam int TILE_SIDE     = 24;
  localparam int BORDER_PERIOD = 36;
  localparam int BORDER_MIN    = 6;
  localparam int ALPHA_BASE    = 96;
  localparam int BOX_MIN       = 24;
  localparam int MOVE_STEP_X   = 11;
  localparam int MOVE_STEP_Y   = 7;

  // Reciprocals for the constant divisions: a 12-bit x over 24 is
  // (x * TILE_RECIP) >> 16, a 16-bit f over 24 is (f * FRAME_TILE_RECIP) >> 20
  // and a 16-bit f over 36 is (f * BORDER_RECIP) >> 21, exact over those ranges.
  localparam int TILE_RECIP       = 2731;
  localparam int FRAME_TILE_RECIP = 43691;
  localparam int BORDER_RECIP     = 58255;

  localparam logic [31:0] FIRST_COLOR_RST  = 32'hCC20A0FF;
  localparam logic [31:0] SECOND_COLOR_RST = 32'hCCFFB020;
  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd240;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd160;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_MODE = 3'd0,
    REG_FIRST_COLOR  = 3'd1,
    REG_SECOND_COLOR = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_CHECKER  = 3'd0,
    MODE_SOLID    = 3'd1,
    MODE_BORDER   = 3'd2,
    MODE_GRADIENT = 3'd3,
    MODE_MOVE     = 3'd4
  } mode_t;

endpackage
`default_nettype wire

/* rtl/core/vtpg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vtpg channel interfaces
// Pixel request, pixel result and register write channels.
// ----------------------------------------------------------------------------
interface vtpg_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_col;
  logic [11:0] pixel_row;
  logic [15:0] frame_number;
  modport source (output valid, pixel_col, pixel_row, frame_number, input ready);
  modport sink   (input valid, pixel_col, pixel_row, frame_number, output ready);
endinterface

interface vtpg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  modport source (output valid, pixel_argb, input ready);
  modport sink   (input valid, pixel_argb, output ready);
endinterface

interface vtpg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vtpg_pkg::CFG_IDX_W-1:0]  index;
  logic [vtpg_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/vtpg_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vtpg_div
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module vtpg_div #(
  parameter int NW = vtpg_pkg::DIV_NW,
  parameter int DW = 13
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o,
  output logic      [DW-1:0] rem_o
);

  logic [DW-1:0] rem_r   [NW];
  logic [NW-1:0] num_r   [NW];
  logic [NW-1:0] quo_r   [NW];
  logic [DW-1:0] rem_nxt [NW];
  logic [NW-1:0] num_nxt [NW];
  logic [NW-1:0] quo_nxt [NW];
  logic [DW:0]   trial   [NW];
  logic [DW-1:0] rem_in  [NW];
  logic [NW-1:0] num_in  [NW];
  logic [NW-1:0] quo_in  [NW];
  logic          ge      [NW];

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      rem_in[k] = (k == 0) ? '0 : rem_r[(k == 0) ? 0 : k-1];
      num_in[k] = (k == 0) ? num_i : num_r[(k == 0) ? 0 : k-1];
      quo_in[k] = (k == 0) ? '0 : quo_r[(k == 0) ? 0 : k-1];
      trial[k]  = {rem_in[k], num_in[k][NW-1]};
      ge[k]     = trial[k] >= {1'b0, den_i};
      rem_nxt[k] = ge[k] ? DW'(trial[k] - {1'b0, den_i}) : trial[k][DW-1:0];
      num_nxt[k] = {num_in[k][NW-2:0], 1'b0};
      quo_nxt[k] = {quo_in[k][NW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo_o = quo_r[NW-1];
  assign rem_o = rem_r[NW-1];

endmodule
`default_nettype wire

/* rtl/core/vtpg_shade.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vtpg_shade
// Final pattern selection from the pixel and the divider results.
// ----------------------------------------------------------------------------
module vtpg_shade #(
  parameter int SW = 13
) (
  input  wire vtpg_pkg::mode_t mode_i,
  input  wire logic [31:0]     first_color_i,
  input  wire logic [31:0]     second_color_i,
  input  wire logic [SW-1:0]   w_i,
  input  wire logic [SW-1:0]   h_i,
  input  wire logic [SW-1:0]   bw_i,
  input  wire logic [SW-1:0]   bh_i,
  input  wire logic [11:0]     x_i,
  input  wire logic [11:0]     y_i,
  input  wire logic [15:0]     f_i,
  input  wire logic            qx_lsb_i,
  input  wire logic [SW-1:0]   rx_i,
  input  wire logic            qy_lsb_i,
  input  wire logic [SW-1:0]   ry_i,
  input  wire logic [SW-1:0]   rf_tile_i,
  input  wire logic [SW-1:0]   rf_border_i,
  input  wire logic [7:0]      red_i,
  input  wire logic [7:0]      green_i,
  input  wire logic [SW-1:0]   box_x_i,
  input  wire logic [SW-1:0]   box_y_i,
  output logic      [31:0]     argb_o
);

  localparam int CW = ((SW > 12) ? SW : 12) + 1;

  logic [5:0]    sum_x, sum_y;
  logic          tile;
  logic [6:0]    band;
  logic          on_border;
  logic [6:0]    a7;
  logic [7:0]    alpha, blue;
  logic          in_box;
  logic [CW-1:0] xe, ye, we, he, be, x0e, y0e;

  always_comb begin
    xe  = CW'(x_i);
    ye  = CW'(y_i);
    we  = CW'(w_i);
    he  = CW'(h_i);
    x0e = CW'(box_x_i);
    y0e = CW'(box_y_i);

    // Shifting by the tile phase moves a pixel into the next tile when the
    // remainder plus the phase wraps past the tile side.
    sum_x = 6'(rx_i) + 6'(rf_tile_i);
    sum_y = 6'(ry_i) + 6'(rf_tile_i);
    tile  = qx_lsb_i ^ qy_lsb_i ^ (sum_x >= 6'(vtpg_pkg::TILE_SIDE))
          ^ (sum_y >= 6'(vtpg_pkg::TILE_SIDE));

    band = 7'(vtpg_pkg::BORDER_MIN) + 7'(rf_border_i);
    be   = CW'(band);
    on_border = (xe < be) || ((xe + be) >= we) || (ye < be) || ((ye + be) >= he);

    a7    = 7'(x_i[6:0] + 7'(3 * f_i[6:0]));
    alpha = 8'(vtpg_pkg::ALPHA_BASE) + {1'b0, a7};
    blue  = 8'(x_i[7:0] + y_i[7:0] + {f_i[4:0], 3'b000});

    in_box = (xe >= x0e) && (xe < x0e + CW'(bw_i)) && (ye >= y0e)
          && (ye < y0e + CW'(bh_i)) && (xe < we) && (ye < he);

    case (mode_i)
      vtpg_pkg::MODE_SOLID:    argb_o = first_color_i;
      vtpg_pkg::MODE_BORDER:   argb_o = on_border ? second_color_i : first_color_i;
      vtpg_pkg::MODE_GRADIENT: argb_o = {alpha, red_i, green_i, blue};
      vtpg_pkg::MODE_MOVE:     argb_o = in_box ? second_color_i : first_color_i;
      default:                 argb_o = tile ? first_color_i : second_color_i;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/video_test_pattern_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// video_test_pattern_generator
// Per-pixel ARGB test pattern source with five selectable patterns.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one pixel request (column, row, frame number) per item;
//   out_ch returns its 32-bit ARGB color, one item per request, in order.
//   cfg_ch writes the mode, the two colors and the frame size; it is always
//   ready and should only be used while no item is in flight.
//   out_ch valid follows the accepting edge through the input stage,
//   twenty divider stages and the output register. One item per cycle is
//   sustained while out_ch does not stall; the bit-per-stage dividers set
//   the depth, not the rate.
//   Synchronous reset clears all valid bits and loads the register defaults.
//   When out_ch stalls with a result held, the whole pipeline freezes and
//   in_ch ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module video_test_pattern_generator #(
  parameter int MAX_SIDE = vtpg_pkg::MAX_SIDE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  vtpg_in_if.sink     in_ch,
  vtpg_out_if.source  out_ch,
  vtpg_cfg_if.sink    cfg_ch
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int EW = (SW > 13) ? SW : 13;
  localparam int NW = vtpg_pkg::DIV_NW;

  vtpg_pkg::mode_t mode_r;
  logic [31:0] c1_r, c2_r;
  logic [12:0] fw_r, fh_r;

  logic [EW-1:0] fw_e, fh_e;
  logic [SW-1:0] w, h, dw, dh, bw, bh, mx, my, w4, h4;

  logic          en;
  logic          v0_r;
  logic [11:0]   x0_r, y0_r;
  logic [15:0]   f0_r;
  logic          vd_r [NW];
  logic [11:0]   xd_r [NW];
  logic [11:0]   yd_r [NW];
  logic [15:0]   fd_r [NW];

  logic [23:0]   px_r, py_r, px_nxt, py_nxt;
  logic [31:0]   pft_r, pfb_r, pft_nxt, pfb_nxt;
  logic [7:0]    tqx, tqy;
  logic [11:0]   tqf;
  logic [10:0]   tqb;
  logic [11:0]   rx_nxt, ry_nxt;
  logic [15:0]   rft_nxt, rfb_nxt;
  logic          qx_lsb_r, qy_lsb_r;
  logic [SW-1:0] rx_r, ry_r, rft_r, rfb_r;

  logic [NW-1:0] qr, qg;
  logic [SW-1:0] rmx, rmy;
  logic [31:0]   argb;
  logic          out_valid_r;
  logic [31:0]   out_argb_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vtpg_pkg::MODE_CHECKER;
      c1_r   <= vtpg_pkg::FIRST_COLOR_RST;
      c2_r   <= vtpg_pkg::SECOND_COLOR_RST;
      fw_r   <= vtpg_pkg::FRAME_WIDTH_RST;
      fh_r   <= vtpg_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        vtpg_pkg::REG_PATTERN_MODE: mode_r <= vtpg_pkg::mode_t'(cfg_ch.data[2:0]);
        vtpg_pkg::REG_FIRST_COLOR:  c1_r   <= cfg_ch.data;
        vtpg_pkg::REG_SECOND_COLOR: c2_r   <= cfg_ch.data;
        vtpg_pkg::REG_FRAME_WIDTH:  fw_r   <= cfg_ch.data[12:0];
        vtpg_pkg::REG_FRAME_HEIGHT: fh_r   <= cfg_ch.data[12:0];
        default: ;
      endcase
    end
  end

  // Frame geometry follows the registers only, so it is shared by all items.
  always_comb begin
    fw_e = EW'(fw_r);
    fh_e = EW'(fh_r);
    w = (fw_e == '0) ? SW'(1) : (fw_e > EW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(fw_e);
    h = (fh_e == '0) ? SW'(1) : (fh_e > EW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(fh_e);
    dw = (w > SW'(1)) ? SW'(w - SW'(1)) : SW'(1);
    dh = (h > SW'(1)) ? SW'(h - SW'(1)) : SW'(1);
    w4 = w >> 2;
    h4 = h >> 2;
    bw = (w4 > SW'(vtpg_pkg::BOX_MIN)) ? w4 : SW'(vtpg_pkg::BOX_MIN);
    bh = (h4 > SW'(vtpg_pkg::BOX_MIN)) ? h4 : SW'(vtpg_pkg::BOX_MIN);
    mx = ((SW+1)'(w) > (SW+1)'(bw) + (SW+1)'(1)) ? SW'(w - bw) : SW'(1);
    my = ((SW+1)'(h) > (SW+1)'(bh) + (SW+1)'(1)) ? SW'(h - bh) : SW'(1);
  end

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int k = 0; k < NW; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
      vd_r[0] <= v0_r;
      for (int k = 1; k < NW; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_ch.pixel_col;
      y0_r <= in_ch.pixel_row;
      f0_r <= in_ch.frame_number;
      xd_r[0] <= x0_r;
      yd_r[0] <= y0_r;
      fd_r[0] <= f0_r;
      for (int k = 1; k < NW; k++) begin
        xd_r[k] <= xd_r[k-1];
        yd_r[k] <= yd_r[k-1];
        fd_r[k] <= fd_r[k-1];
      end
    end
  end

  // Tile and band phases divide by constants: a reciprocal product from the
  // third-to-last delay stage, then the remainder from the second-to-last one,
  // so both line up with the divider outputs.
  always_comb begin
    px_nxt  = 24'(xd_r[NW-3]) * 24'(vtpg_pkg::TILE_RECIP);
    py_nxt  = 24'(yd_r[NW-3]) * 24'(vtpg_pkg::TILE_RECIP);
    pft_nxt = 32'(fd_r[NW-3]) * 32'(vtpg_pkg::FRAME_TILE_RECIP);
    pfb_nxt = 32'(fd_r[NW-3]) * 32'(vtpg_pkg::BORDER_RECIP);
    tqx = px_r[23:16];
    tqy = py_r[23:16];
    tqf = pft_r[31:20];
    tqb = pfb_r[31:21];
    rx_nxt  = xd_r[NW-2] - {tqx, 4'b0000} - {1'b0, tqx, 3'b000};
    ry_nxt  = yd_r[NW-2] - {tqy, 4'b0000} - {1'b0, tqy, 3'b000};
    rft_nxt = fd_r[NW-2] - {tqf, 4'b0000} - {1'b0, tqf, 3'b000};
    rfb_nxt = fd_r[NW-2] - {tqb, 5'b00000} - {3'b000, tqb, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      pft_r    <= pft_nxt;
      pfb_r    <= pfb_nxt;
      qx_lsb_r <= tqx[0];
      qy_lsb_r <= tqy[0];
      rx_r     <= SW'(rx_nxt[4:0]);
      ry_r     <= SW'(ry_nxt[4:0]);
      rft_r    <= SW'(rft_nxt[4:0]);
      rfb_r    <= SW'(rfb_nxt[5:0]);
    end
  end

  vtpg_div #(.NW(NW), .DW(SW)) u_div_r (
    .clk(clk), .en(en), .num_i(NW'({x0_r, 8'b0}) - NW'(x0_r)), .den_i(dw),
    .quo_o(qr), .rem_o());
  vtpg_div #(.NW(NW), .DW(SW)) u_div_g (
    .clk(clk), .en(en), .num_i(NW'({y0_r, 8'b0}) - NW'(y0_r)), .den_i(dh),
    .quo_o(qg), .rem_o());
  vtpg_div #(.NW(NW), .DW(SW)) u_div_mx (
    .clk(clk), .en(en), .num_i(NW'(f0_r * vtpg_pkg::MOVE_STEP_X)), .den_i(mx),
    .quo_o(), .rem_o(rmx));
  vtpg_div #(.NW(NW), .DW(SW)) u_div_my (
    .clk(clk), .en(en), .num_i(NW'(f0_r * vtpg_pkg::MOVE_STEP_Y)), .den_i(my),
    .quo_o(), .rem_o(rmy));

  vtpg_shade #(.SW(SW)) u_shade (
    .mode_i(mode_r), .first_color_i(c1_r), .second_color_i(c2_r),
    .w_i(w), .h_i(h), .bw_i(bw), .bh_i(bh),
    .x_i(xd_r[NW-1]), .y_i(yd_r[NW-1]), .f_i(fd_r[NW-1]),
    .qx_lsb_i(qx_lsb_r), .rx_i(rx_r), .qy_lsb_i(qy_lsb_r), .ry_i(ry_r),
    .rf_tile_i(rft_r), .rf_border_i(rfb_r),
    .red_i(qr[7:0]), .green_i(qg[7:0]),
    .box_x_i(rmx), .box_y_i(rmy),
    .argb_o(argb));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_argb_r <= argb;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_argb = out_argb_r;

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> ($stable(vd_r[NW-1]) && $stable(v0_r)))
    else $error("pipeline moved during output stall");
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !vd_r[NW-1]) |=> !out_valid_r)
    else $error("result without item in last stage");
`endif

endmodule
`default_nettype wire
